### sv/assert_macros.svh
// Concurrent assertion macros, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MDPA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MDPA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mdpa_pkg.sv
// Shared types and constants of the point pair admission filter.
`timescale 1ns / 1ps

package mdpa_pkg;

    localparam int COORD_W    = 16;   // coordinate port width
    localparam int DIST_W     = 16;   // min_distance register width
    localparam int LIM2_W     = 32;   // squared minimum distance
    localparam int SLOT_W     = 5;
    localparam int CNT_OUT_W  = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [DIST_W-1:0] MIN_DIST_RESET = 16'd50;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_MIN_DISTANCE = 1'b0;

    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_SRC_CLOSE = 2'd1,
        ST_TRG_CLOSE = 2'd2,
        ST_FULL      = 2'd3
    } mdpa_status_t;

    // Result of one distance unit toward the sequencer.
    typedef struct packed {
        logic valid;   // close is meaningful this cycle
        logic close;   // squared distance below the limit
        logic busy;    // compares still in flight
    } mdpa_hit_t;

endpackage

### sv/mdpa_store.sv
// Point pair memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module mdpa_store
    import mdpa_pkg::*;
#(
    parameter int MAX_PAIRS  = 32,
    parameter int COORD_BITS = 16,
    localparam int ADDR_W    = $clog2(MAX_PAIRS),
    localparam int DATA_W    = 6 * COORD_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    output logic              rd_valid
);

    logic [DATA_W-1:0] mem [MAX_PAIRS];
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

### sv/mdpa_dist.sv
// Pipelined squared distance compare of one stored point against a probe.
`timescale 1ns / 1ps

module mdpa_dist
    import mdpa_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int PT_W      = 3 * COORD_BITS,
    localparam int ABS_W     = COORD_BITS + 1,
    localparam int SQ_W      = 2 * ABS_W,
    localparam int SUM_W     = SQ_W + 2,
    localparam int CMP_W     = (SUM_W > LIM2_W) ? SUM_W : LIM2_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [PT_W-1:0]   stored_pt,
    input  logic [PT_W-1:0]   probe_pt,
    input  logic [LIM2_W-1:0] lim2,
    output mdpa_hit_t         hit
);

    logic signed [COORD_BITS:0] diff [3];
    logic [ABS_W-1:0] abs_next [3];
    logic [ABS_W-1:0] abs_reg  [3];
    logic [SQ_W-1:0]  sq_next  [3];
    logic [SQ_W-1:0]  sq_reg   [3];
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_reg;
    logic             close_next;
    logic             close_reg;
    logic [3:0]       vld_reg;

    // Per-axis difference and magnitude; the axes are independent.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = $signed({stored_pt[k*COORD_BITS + COORD_BITS - 1],
                               stored_pt[k*COORD_BITS +: COORD_BITS]})
                    - $signed({probe_pt[k*COORD_BITS + COORD_BITS - 1],
                               probe_pt[k*COORD_BITS +: COORD_BITS]});
            abs_next[k] = diff[k][COORD_BITS] ? ABS_W'(-diff[k]) : ABS_W'(diff[k]);
            sq_next[k]  = SQ_W'(abs_reg[k]) * SQ_W'(abs_reg[k]);
        end
        sum_next   = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        close_next = CMP_W'(sum_reg) < CMP_W'(lim2);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            abs_reg[k] <= abs_next[k];
            sq_reg[k]  <= sq_next[k];
        end
        sum_reg   <= sum_next;
        close_reg <= close_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    assign hit.valid = vld_reg[3];
    assign hit.close = close_reg;
    assign hit.busy  = |vld_reg;

endmodule

### sv/min_distance_point_pair_admission_top.sv
// Minimum distance point pair admission filter, top level.
// Each transfer on the input channel offers a source point and a target point
// (signed millimetres, sign-extended from the low COORD_BITS bits of each
// 16-bit field). The pair is stored unless a stored source point lies closer
// than min_distance to the new source point (status 1), a stored target point
// lies that close to the new target point (status 2), or the store already
// holds MAX_PAIRS pairs (status 3); the test is exact on squared distances.
// One result transfer follows every input transfer. The sequencer reads one
// stored pair per cycle from the pair memory, both distance units compare in
// lockstep, and the read register and the magnitude, square, sum and compare
// registers of the distance units drain before the decision and write-back.
// An empty or full store skips the scan and goes straight to the decision.
// The result sits in an output register, so the input side reopens as soon
// as the decision is made.
// min_distance (reset 50) lives at byte address 0 of the APB port and must
// only be written while no item is in flight.
`timescale 1ns / 1ps

module min_distance_point_pair_admission_top
    import mdpa_pkg::*;
#(
    parameter int MAX_PAIRS  = 32,
    parameter int COORD_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // APB configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    // input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [COORD_W-1:0] src_x,
    input  logic signed [COORD_W-1:0] src_y,
    input  logic signed [COORD_W-1:0] src_z,
    input  logic signed [COORD_W-1:0] trg_x,
    input  logic signed [COORD_W-1:0] trg_y,
    input  logic signed [COORD_W-1:0] trg_z,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     accepted,
    output logic [1:0]               status,
    output logic [SLOT_W-1:0]        slot,
    output logic [CNT_OUT_W-1:0]     stored_count
);

    `include "assert_macros.svh"

    localparam int ADDR_W = $clog2(MAX_PAIRS);
    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int PT_W   = 3 * COORD_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } state_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] min_dist_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MIN_DISTANCE);
    assign prdata = (paddr[2] == REG_MIN_DISTANCE) ? APB_DATA_W'(min_dist_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= MIN_DIST_RESET;
        end
        else if (cfg_wr)
        begin
            min_dist_reg <= pwdata[DIST_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t              state_reg,   state_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [ADDR_W-1:0]   idx_reg,     idx_next;
    logic [PT_W-1:0]     src_pt_reg,  src_pt_next;
    logic [PT_W-1:0]     trg_pt_reg,  trg_pt_next;
    logic [LIM2_W-1:0]   lim2_reg,    lim2_next;
    logic                src_hit_reg, src_hit_next;
    logic                trg_hit_reg, trg_hit_next;
    logic                out_valid_reg,    out_valid_next;
    logic                accepted_reg,     accepted_next;
    mdpa_status_t        status_reg,       status_next;
    logic [SLOT_W-1:0]   slot_reg,         slot_next;
    logic [CNT_OUT_W-1:0] stored_count_reg, stored_count_next;

    logic                rd_en;
    logic                wr_en;
    logic [PT_W*2-1:0]   rd_data;
    logic                rd_valid;
    mdpa_hit_t           src_res;
    mdpa_hit_t           trg_res;
    logic                store_full;

    assign in_ready   = (state_reg == S_IDLE);
    assign store_full = (count_reg == CNT_W'(MAX_PAIRS));

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        src_pt_next       = src_pt_reg;
        trg_pt_next       = trg_pt_reg;
        lim2_next         = lim2_reg;
        src_hit_next      = src_hit_reg;
        trg_hit_next      = trg_hit_reg;
        out_valid_next    = out_valid_reg;
        accepted_next     = accepted_reg;
        status_next       = status_reg;
        slot_next         = slot_reg;
        stored_count_next = stored_count_reg;
        rd_en             = 1'b0;
        wr_en             = 1'b0;

        // drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // accumulate compare outcomes as they leave the distance units
        if (src_res.valid && src_res.close)
        begin
            src_hit_next = 1'b1;
        end
        if (trg_res.valid && trg_res.close)
        begin
            trg_hit_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    src_pt_next  = {COORD_BITS'($unsigned(src_z)),
                                    COORD_BITS'($unsigned(src_y)),
                                    COORD_BITS'($unsigned(src_x))};
                    trg_pt_next  = {COORD_BITS'($unsigned(trg_z)),
                                    COORD_BITS'($unsigned(trg_y)),
                                    COORD_BITS'($unsigned(trg_x))};
                    lim2_next    = {16'b0, min_dist_reg} * {16'b0, min_dist_reg};
                    src_hit_next = 1'b0;
                    trg_hit_next = 1'b0;
                    idx_next     = '0;
                    // empty or full store needs no scan
                    if (store_full || (count_reg == '0))
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                rd_en    = 1'b1;
                idx_next = idx_reg + ADDR_W'(1);
                if ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                if (!rd_valid && !src_res.busy && !trg_res.busy)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    accepted_next     = 1'b0;
                    slot_next         = '0;
                    stored_count_next = CNT_OUT_W'(count_reg);
                    if (store_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (src_hit_reg)
                    begin
                        status_next = ST_SRC_CLOSE;
                    end
                    else if (trg_hit_reg)
                    begin
                        status_next = ST_TRG_CLOSE;
                    end
                    else
                    begin
                        status_next       = ST_STORED;
                        accepted_next     = 1'b1;
                        wr_en             = 1'b1;
                        slot_next         = SLOT_W'(count_reg);
                        count_next        = count_reg + CNT_W'(1);
                        stored_count_next = CNT_OUT_W'(count_reg + CNT_W'(1));
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            src_pt_reg       <= '0;
            trg_pt_reg       <= '0;
            lim2_reg         <= '0;
            src_hit_reg      <= 1'b0;
            trg_hit_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            accepted_reg     <= 1'b0;
            status_reg       <= ST_STORED;
            slot_reg         <= '0;
            stored_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            src_pt_reg       <= src_pt_next;
            trg_pt_reg       <= trg_pt_next;
            lim2_reg         <= lim2_next;
            src_hit_reg      <= src_hit_next;
            trg_hit_reg      <= trg_hit_next;
            out_valid_reg    <= out_valid_next;
            accepted_reg     <= accepted_next;
            status_reg       <= status_next;
            slot_reg         <= slot_next;
            stored_count_reg <= stored_count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign stored_count = stored_count_reg;

    // ------------------------------------------------------------------
    // Pair memory: source point in the low half, target point in the high
    // ------------------------------------------------------------------
    mdpa_store #(
        .MAX_PAIRS  (MAX_PAIRS),
        .COORD_BITS (COORD_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[ADDR_W-1:0]),
        .wr_data  ({trg_pt_reg, src_pt_reg}),
        .rd_en    (rd_en),
        .rd_addr  (idx_reg),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    // ------------------------------------------------------------------
    // Distance units, one per point set, in lockstep
    // ------------------------------------------------------------------
    mdpa_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_src_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid),
        .stored_pt (rd_data[PT_W-1:0]),
        .probe_pt  (src_pt_reg),
        .lim2      (lim2_reg),
        .hit       (src_res)
    );

    mdpa_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_trg_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid),
        .stored_pt (rd_data[2*PT_W-1:PT_W]),
        .probe_pt  (trg_pt_reg),
        .lim2      (lim2_reg),
        .hit       (trg_res)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MDPA_ASSERT_IMP(a_no_rw_overlap, wr_en, !rd_en && !rd_valid && !src_res.busy,
        "pair memory written while a scan is still in flight")
    `MDPA_ASSERT_IMP(a_write_not_full, wr_en, count_reg < CNT_W'(MAX_PAIRS),
        "pair memory written with the store full")
    `MDPA_ASSERT_NXT(a_count_step, wr_en, count_reg == $past(count_reg) + CNT_W'(1),
        "pair count did not advance after a store write")
    `MDPA_ASSERT_IMP(a_ready_idle_pipe, in_ready, !src_res.busy && !trg_res.busy,
        "input ready while compares are still in flight")
    `MDPA_ASSERT_IMP(a_accept_status, out_valid_reg && accepted_reg,
        status_reg == ST_STORED,
        "accepted result carries a reject status")

endmodule

### dv/tb_min_distance_point_pair_admission_top.sv
// Self-checking testbench for the minimum distance point pair admission filter.
`timescale 1ns / 1ps

module tb_min_distance_point_pair_admission_top;
    import mdpa_pkg::*;

    localparam int     PAIR_CAP     = 32;         // MAX_PAIRS of the instance
    localparam int     HALF_PERIOD  = 2;          // 4 ns clock
    localparam int     RESET_CYCLES = 4;
    localparam int     HOLD_CYCLES  = 400;        // long receiver hold-off
    localparam int     TAIL_CYCLES  = 60;         // more than one full scan
    localparam int     REPORT_CAP   = 40;         // printed mismatch lines
    localparam longint CYCLE_LIMIT  = 1000000;

    // Byte address of min_distance: the register index sits on the word bit.
    localparam logic [APB_ADDR_W-1:0] MIN_DIST_ADDR = {REG_MIN_DISTANCE, 2'b00};

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    // One input transfer: a source point and its corresponding target point.
    typedef struct packed {
        point_t src;
        point_t trg;
    } pair_item_t;

    // One result transfer.
    typedef struct packed {
        logic                 acc;
        mdpa_status_t         st;
        logic [SLOT_W-1:0]    slot;
        logic [CNT_OUT_W-1:0] cnt;
    } pair_verdict_t;

    typedef enum {FLOW_STEADY, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_mode_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] cfg_rdata;
    logic                  cfg_ready;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    pair_item_t            offer        = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  accepted;
    logic [1:0]            status;
    logic [SLOT_W-1:0]     slot;
    logic [CNT_OUT_W-1:0]  stored_count;

    // Mirror of the filter: stored pairs, pair count and the distance register.
    point_t        kept_src [PAIR_CAP];
    point_t        kept_trg [PAIR_CAP];
    int            kept_count   = 0;
    logic [15:0]   min_dist_cfg = MIN_DIST_RESET;

    pair_item_t    pair_backlog [$];   // items waiting to be offered
    pair_verdict_t verdicts_owed [$]; // expected results, oldest first
    int            pairs_open     = 0;  // popped from the backlog, result not back yet
    int            mismatch_count = 0;
    int            results_seen   = 0;
    int            spare_accepts  = 0;  // items per phase allowed to grow the store freely
    longint        cycle_count    = 0;
    flow_mode_t    flow           = FLOW_STEADY;
    int            hold_ticket    = 0;
    int            hold_seen      = 0;
    int            hold_left      = 0;

    min_distance_point_pair_admission_top #(
        .MAX_PAIRS  (PAIR_CAP),
        .COORD_BITS (COORD_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (cfg_rdata),
        .pready       (cfg_ready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_x        (offer.src.x),
        .src_y        (offer.src.y),
        .src_z        (offer.src.z),
        .trg_x        (offer.trg.x),
        .trg_y        (offer.trg.y),
        .trg_z        (offer.trg.z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .status       (status),
        .slot         (slot),
        .stored_count (stored_count)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Exact test on squared distance: closer means strictly below the limit.
    function automatic bit closer_than_limit(input point_t a, input point_t b);
        longint dx;
        longint dy;
        longint dz;
        longint lim;
        dx  = longint'($signed(a.x)) - longint'($signed(b.x));
        dy  = longint'($signed(a.y)) - longint'($signed(b.y));
        dz  = longint'($signed(a.z)) - longint'($signed(b.z));
        lim = longint'(min_dist_cfg) * longint'(min_dist_cfg);
        return (dx * dx + dy * dy + dz * dz) < lim;
    endfunction

    // Scan the stored source or target points for one that crowds p.
    function automatic bit crowded(input bit on_target, input point_t p);
        for (int i = 0; i < kept_count; i++)
        begin
            if (closer_than_limit(on_target ? kept_trg[i] : kept_src[i], p))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Judge one pair and store it when admitted. Full store wins over the
    // distance tests; the source test comes before the target test.
    function automatic pair_verdict_t admit_pair(input pair_item_t item);
        pair_verdict_t v;
        v.acc  = 1'b0;
        v.slot = '0;
        if (kept_count >= PAIR_CAP)
        begin
            v.st = ST_FULL;
        end
        else if (crowded(1'b0, item.src))
        begin
            v.st = ST_SRC_CLOSE;
        end
        else if (crowded(1'b1, item.trg))
        begin
            v.st = ST_TRG_CLOSE;
        end
        else
        begin
            kept_src[kept_count] = item.src;
            kept_trg[kept_count] = item.trg;
            v.slot     = kept_count[SLOT_W-1:0];
            kept_count = kept_count + 1;
            v.acc      = 1'b1;
            v.st       = ST_STORED;
        end
        v.cnt = kept_count[CNT_OUT_W-1:0];
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Append one item at the tail of the backlog.
    function automatic void queue_item(input pair_item_t it);
        pair_backlog.insert(pair_backlog.size(), it);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[COORD_W-1:0];
    endfunction

    function automatic point_t any_point();
        point_t p;
        p.x = COORD_W'($urandom());
        p.y = COORD_W'($urandom());
        p.z = COORD_W'($urandom());
        return p;
    endfunction

    function automatic logic signed [COORD_W-1:0] extreme_coord();
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    // Jitter every axis of base by at most span; with span at half the
    // minimum distance the squared distance stays below its square, so the
    // point is close.
    function automatic point_t scatter(input point_t base, input int span);
        point_t p;
        p.x = clamp_coord(longint'($signed(base.x)) + $urandom_range(2 * span) - span);
        p.y = clamp_coord(longint'($signed(base.y)) + $urandom_range(2 * span) - span);
        p.z = clamp_coord(longint'($signed(base.z)) + $urandom_range(2 * span) - span);
        return p;
    endfunction

    function automatic pair_item_t make_pair(input int sx, input int sy, input int sz,
                                             input int tx, input int ty, input int tz);
        pair_item_t it;
        it.src = {sx[15:0], sy[15:0], sz[15:0]};
        it.trg = {tx[15:0], ty[15:0], tz[15:0]};
        return it;
    endfunction

    // Draw one random item. Most items aim at stored points so the store
    // fills slowly and the scans run long; a few budgeted ones go anywhere.
    function automatic pair_item_t compose_item(input logic [15:0] min_mm);
        pair_item_t it;
        int         roll;
        int         k;
        int         j;
        int         span;
        longint     stride;
        span = int'(min_mm) / 2;
        roll = int'($urandom_range(99));
        k    = (kept_count > 0) ? int'($urandom_range(kept_count - 1)) : 0;
        j    = (kept_count > 0) ? int'($urandom_range(kept_count - 1)) : 0;
        if (kept_count == 0 || (roll >= 98 && spare_accepts > 0))
        begin
            if (spare_accepts > 0)
                spare_accepts = spare_accepts - 1;
            if ($urandom_range(1))
            begin
                it.src = any_point();
                it.trg = any_point();
            end
            else
            begin
                it.src = {extreme_coord(), extreme_coord(), extreme_coord()};
                it.trg = {extreme_coord(), extreme_coord(), extreme_coord()};
            end
        end
        else if (roll < 45)
        begin
            // source close; below 20 the target is close as well
            it.src = scatter(kept_src[k], span);
            it.trg = (roll < 20) ? scatter(kept_trg[j], span) : any_point();
        end
        else if (roll < 75)
        begin
            it.src = any_point();
            it.trg = scatter(kept_trg[j], span);
        end
        else
        begin
            // source right on the limit or one below it along one axis
            stride = $urandom_range(1) ? longint'(min_mm) : longint'(min_mm) - 1;
            if ($urandom_range(1))
                stride = -stride;
            it.src = kept_src[k];
            case ($urandom_range(2))
                0:       it.src.x = clamp_coord(longint'($signed(it.src.x)) + stride);
                1:       it.src.y = clamp_coord(longint'($signed(it.src.y)) + stride);
                default: it.src.z = clamp_coord(longint'($signed(it.src.z)) + stride);
            endcase
            it.trg = scatter(kept_trg[j], span);
        end
        return it;
    endfunction

    function automatic bit sender_gap();
        case (flow)
            FLOW_SEND_GAPS: return $urandom_range(99) < 70;
            FLOW_BOTH:      return $urandom_range(99) < 28;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (flow)
            FLOW_RECV_STALLS: return $urandom_range(99) < 70;
            FLOW_BOTH:        return $urandom_range(99) < 28;
            default:          return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offer backlog items, predict each one at its transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : pair_sender
        logic load;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                verdicts_owed.insert(verdicts_owed.size(), admit_pair(offer));
            // Hold valid and payload until the transfer; otherwise refill.
            if (!in_valid || in_ready)
            begin
                load = (pair_backlog.size() != 0) && !sender_gap();
                if (load)
                begin
                    offer      <= pair_backlog.pop_front();
                    pairs_open  = pairs_open + 1;
                end
                in_valid <= load;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_ticket)
        begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !receiver_stall();
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare every result transfer with the oldest verdict
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_CAP)
            $display("[%0t] result %0d: %s is %0d, predicted %0d",
                     $realtime, results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin : result_watch
        pair_verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen = results_seen + 1;
            if (verdicts_owed.size() == 0)
            begin
                report_mismatch("unexpected result, pending count", 32'd0, 32'd0);
            end
            else
            begin
                want       = verdicts_owed.pop_front();
                pairs_open = pairs_open - 1;
                if (accepted !== want.acc)
                    report_mismatch("accepted", 32'(accepted), 32'(want.acc));
                if (status !== want.st)
                    report_mismatch("status", 32'(status), 32'(want.st));
                if (slot !== want.slot)
                    report_mismatch("slot", 32'(slot), 32'(want.slot));
                if (stored_count !== want.cnt)
                    report_mismatch("stored_count", 32'(stored_count), 32'(want.cnt));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    // Wait until every offered item has its result back, then let the
    // block settle.
    task automatic settle_pipeline();
        while (pair_backlog.size() != 0 || pairs_open != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of min_distance: setup cycle, then access cycle; the register
    // takes the value at the access edge, and so does the mirror. Then read the
    // register back.
    task automatic write_min_distance(input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_DIST_ADDR;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        min_dist_cfg = value;
        @(posedge clk);
        if (cfg_ready !== 1'b1)
            report_mismatch("pready", 32'(cfg_ready), 32'd1);
        if (cfg_rdata !== {16'd0, value})
            report_mismatch("min_distance readback", cfg_rdata, {16'd0, value});
    endtask

    // One random phase: new distance and idle pattern, then two halves with
    // a full drain before each half, so the sender pauses twice per phase.
    task automatic run_phase(input int n_items, input logic [15:0] min_mm,
                             input flow_mode_t mode, input bit long_hold);
        int i;
        settle_pipeline();
        write_min_distance(min_mm);
        flow          = mode;
        spare_accepts = (kept_count < 24) ? 3 : 0;
        for (i = 0; i < n_items / 2; i++)
            queue_item(compose_item(min_mm));
        // Stop taking results while the sender keeps going; the block
        // fills its output register and stalls the input.
        if (long_hold)
            hold_ticket <= hold_ticket + 1;
        settle_pipeline();
        for (i = n_items / 2; i < n_items; i++)
            queue_item(compose_item(min_mm));
    endtask

    initial
    begin : run_timeout
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset distance of 50.
        queue_item(make_pair(0, 0, 0, 0, 0, 0));         // empty store
        queue_item(make_pair(49, 0, 0, 900, 900, 900));  // source one short
        queue_item(make_pair(50, 0, 0, 0, 0, 1));        // target close
        queue_item(make_pair(0, 30, 40, 0, 0, 50));      // both exactly on limit
        queue_item(make_pair(1, 1, 1, 1, 1, 1));         // both close
        queue_item(make_pair(-32768, -32768, -32768, 32767, 32767, 32767));
        queue_item(make_pair(32767, 32767, 32767, -32768, -32768, -32768));
        queue_item(make_pair(32767, -32768, 32767, -32768, 32767, -32768));
        queue_item(make_pair(-32768, -32768, -32767, 5000, 5000, 5000));
        queue_item(make_pair(100, 100, 100, 32767, 32767, 32766));
        settle_pipeline();

        // Largest distance: almost nothing fits any more.
        write_min_distance(16'hFFFF);
        queue_item(make_pair(32767, -32768, -32768, 0, 0, 0));
        settle_pipeline();

        // Zero distance: duplicates of stored points get in.
        write_min_distance(16'd0);
        queue_item(make_pair(0, 0, 0, 0, 0, 0));
        settle_pipeline();

        // Distance one: only identical points are close.
        write_min_distance(16'd1);
        queue_item(make_pair(0, 0, 0, 7, 7, 7));
        queue_item(make_pair(1, 0, 0, 0, 0, 0));

        // Random phases across distances and idle patterns; the store is
        // filled on purpose near the end and then tested while full.
        run_phase(220, 16'd50, FLOW_STEADY, 1'b0);
        run_phase(220, 16'd1, FLOW_SEND_GAPS, 1'b0);
        run_phase(220, 16'hFFFF, FLOW_RECV_STALLS, 1'b0);
        run_phase(220, 16'd1000, FLOW_BOTH, 1'b0);
        run_phase(220, 16'($urandom_range(65534, 2)), FLOW_STEADY, 1'b1);
        run_phase(220, 16'd300, FLOW_SEND_GAPS, 1'b0);
        run_phase(220, 16'($urandom_range(20, 2)), FLOW_RECV_STALLS, 1'b0);
        run_phase(150, 16'd0, FLOW_BOTH, 1'b0);
        run_phase(50, 16'hFFFF, FLOW_STEADY, 1'b0);

        settle_pipeline();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/mdpa_pkg.sv
sv/mdpa_store.sv
sv/mdpa_dist.sv
sv/min_distance_point_pair_admission_top.sv
dv/tb_min_distance_point_pair_admission_top.sv
